FILE: sv/error_diffusion_dither_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the error diffusion dither unit
// Shared concurrent-assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_UNIT_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EDD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("edd assertion failed");

// Next-cycle implication.
`define EDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("edd assertion failed");

`endif

FILE: sv/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// Constants, types and the kernel tap table of the error diffusion dither.
// ----------------------------------------------------------------------------
package edd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int MEM_DEPTH  = 3 * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int ERR_W      = 16;
    localparam int E_W        = 13;
    localparam int TAP_W      = 4;
    localparam int FS_TAPS    = 4;
    localparam int JJN_TAPS   = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SEL   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERPENTINE   = 8'd3;

    // One classified pixel, front to back
    typedef struct packed {
        logic [7:0]       pixel;
        logic [COL_W-1:0] x;
        logic             rev;
        logic [1:0]       slot;
        logic             jjn;
        logic [WID_W-1:0] width;
        logic             row_end;
        logic             frame_end;
    } edd_item_t;

    // One kernel tap: row below, column offset (forward scan), weight
    typedef struct packed {
        logic [1:0]        row;
        logic signed [2:0] dx;
        logic [2:0]        wgt;
    } edd_tap_t;

    function automatic edd_tap_t edd_tap(input logic jjn, input logic [TAP_W-1:0] k);
        edd_tap_t t;
        t = '{row: 2'd0, dx: 3'sd0, wgt: 3'd0};
        if (!jjn) begin
            case (k)
                4'd0: t = '{row: 2'd0, dx:  3'sd1, wgt: 3'd7};
                4'd1: t = '{row: 2'd1, dx: -3'sd1, wgt: 3'd3};
                4'd2: t = '{row: 2'd1, dx:  3'sd0, wgt: 3'd5};
                4'd3: t = '{row: 2'd1, dx:  3'sd1, wgt: 3'd1};
                default: t = '{row: 2'd0, dx: 3'sd0, wgt: 3'd0};
            endcase
        end else begin
            case (k)
                4'd0:  t = '{row: 2'd0, dx:  3'sd1, wgt: 3'd7};
                4'd1:  t = '{row: 2'd0, dx:  3'sd2, wgt: 3'd5};
                4'd2:  t = '{row: 2'd1, dx: -3'sd2, wgt: 3'd3};
                4'd3:  t = '{row: 2'd1, dx: -3'sd1, wgt: 3'd5};
                4'd4:  t = '{row: 2'd1, dx:  3'sd0, wgt: 3'd7};
                4'd5:  t = '{row: 2'd1, dx:  3'sd1, wgt: 3'd5};
                4'd6:  t = '{row: 2'd1, dx:  3'sd2, wgt: 3'd3};
                4'd7:  t = '{row: 2'd2, dx: -3'sd2, wgt: 3'd1};
                4'd8:  t = '{row: 2'd2, dx: -3'sd1, wgt: 3'd3};
                4'd9:  t = '{row: 2'd2, dx:  3'sd0, wgt: 3'd5};
                4'd10: t = '{row: 2'd2, dx:  3'sd1, wgt: 3'd3};
                4'd11: t = '{row: 2'd2, dx:  3'sd2, wgt: 3'd1};
                default: t = '{row: 2'd0, dx: 3'sd0, wgt: 3'd0};
            endcase
        end
        return t;
    endfunction

endpackage

FILE: sv/edd_front.sv
// ----------------------------------------------------------------------------
// edd_front
// Configuration registers and scan tracking; classifies each accepted pixel.
// ----------------------------------------------------------------------------
module edd_front import edd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            pixel,
    output edd_item_t             item
);

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             kernel_reg;
    logic             serp_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [1:0]       slot_reg;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [COL_W-1:0] col_eff;
    logic             rev;
    logic [WID_W-1:0] x_wide;
    logic             row_end;
    logic             frame_end;

    // Clamp the geometry registers into range
    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) w_eff = WID_W'(1);
        else if (width_reg > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0) h_eff = HGT_W'(1);
        else if (height_reg > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    end

    // Locate the pixel within the row
    always_comb begin
        col_eff = col_reg;
        if ({1'b0, col_reg} >= w_eff) col_eff = COL_W'(w_eff - WID_W'(1));
        rev       = serp_reg & row_reg[0];
        x_wide    = w_eff - WID_W'(1) - {1'b0, col_eff};
        row_end   = ({1'b0, col_eff} + WID_W'(1)) >= w_eff;
        frame_end = row_end && (({1'b0, row_reg} + HGT_W'(1)) >= h_eff);
    end

    always_comb begin
        item.pixel     = pixel;
        item.x         = rev ? x_wide[COL_W-1:0] : col_eff;
        item.rev       = rev;
        item.slot      = slot_reg;
        item.jjn       = kernel_reg;
        item.width     = w_eff;
        item.row_end   = row_end;
        item.frame_end = frame_end;
    end

    // Hold configuration and advance the scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WID_W'(1024);
            height_reg <= HGT_W'(480);
            kernel_reg <= 1'b0;
            serp_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                    CFG_KERNEL_SEL:   kernel_reg <= cfg_data[0];
                    CFG_SERPENTINE:   serp_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (frame_end) begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    slot_reg <= '0;
                end else if (row_end) begin
                    col_reg  <= '0;
                    row_reg  <= row_reg + ROW_W'(1);
                    slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                end else begin
                    col_reg  <= col_eff + COL_W'(1);
                end
            end
        end
    end

endmodule

FILE: sv/edd_queue.sv
// ----------------------------------------------------------------------------
// edd_queue
// Four-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module edd_queue import edd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  edd_item_t push_item,
    input  logic      pop,
    output edd_item_t head,
    output logic      full,
    output logic      empty
);

    edd_item_t  mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] count_reg;

    assign head  = mem_reg[rp_reg];
    assign full  = count_reg == 3'd4;
    assign empty = count_reg == 3'd0;

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_item;
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: sv/edd_back.sv
// ----------------------------------------------------------------------------
// edd_back
// Error memory sequencer: reads the pixel's error, thresholds, spreads taps.
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_unit_defines.svh"

module edd_back import edd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  edd_item_t head,
    input  logic      empty,
    output logic      pop,
    output logic      clearing,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,
    output logic      m_tlast,
    output logic      m_tuser
);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_TAP, ST_WB} state_t;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

    logic signed [ERR_W-1:0] err_mem [MEM_DEPTH];
    logic signed [ERR_W-1:0] rdata_reg;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    edd_item_t              cur_reg;
    logic [TAP_W-1:0]       k_reg;
    logic signed [E_W-1:0]  e_reg;
    logic                   pw_valid_reg;
    logic [ADDR_W-1:0]      pw_addr_reg;
    logic [2:0]             pw_wgt_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_pix_reg;
    logic                   out_last_reg;
    logic                   out_user_reg;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [1:0] slot,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    // Tap decode for the current step
    edd_tap_t              tap;
    logic signed [2:0]     dx_eff;
    logic signed [COL_W+1:0] tx;
    logic                  tap_ok;
    logic [2:0]            slot_sum;
    logic [1:0]            tap_slot;
    logic [ADDR_W-1:0]     tap_addr;
    logic [TAP_W-1:0]      last_k;

    always_comb begin
        tap      = edd_tap(cur_reg.jjn, k_reg);
        dx_eff   = cur_reg.rev ? -tap.dx : tap.dx;
        tx       = $signed({2'b00, cur_reg.x}) + $signed({{(COL_W-1){dx_eff[2]}}, dx_eff});
        tap_ok   = !tx[COL_W+1] && (tx[COL_W:0] < cur_reg.width);
        slot_sum = {1'b0, cur_reg.slot} + {1'b0, tap.row};
        tap_slot = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
        tap_addr = row_addr(tap_slot, tx[COL_W-1:0]);
        last_k   = cur_reg.jjn ? TAP_W'(JJN_TAPS - 1) : TAP_W'(FS_TAPS - 1);
    end

    // Threshold the pixel against its diffused error
    logic [ERR_W:0]        mag;
    logic [11:0]           m16;
    logic [23:0]           prod3;
    logic [11:0]           q;
    logic signed [E_W-1:0] sq;
    logic signed [E_W-1:0] val;
    logic                  white;
    logic signed [E_W-1:0] e_new;

    always_comb begin
        mag   = rdata_reg[ERR_W-1] ? (ERR_W+1)'(-$signed({rdata_reg[ERR_W-1], rdata_reg}))
                                   : {1'b0, rdata_reg};
        m16   = mag[15:4];
        prod3 = 24'(m16) * 24'd2731;
        q     = cur_reg.jjn ? {1'b0, prod3[24-1:13]} : m16;
        sq    = rdata_reg[ERR_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        val   = $signed({5'b0, cur_reg.pixel}) + sq;
        white = val >= $signed(E_W'(128));
        e_new = white ? val - $signed(E_W'(255)) : val;
    end

    // Saturating add of the previous tap's share
    logic signed [16:0]      share;
    logic signed [17:0]      sum;
    logic signed [ERR_W-1:0] sat;

    always_comb begin
        share = 17'(e_reg * $signed({1'b0, pw_wgt_reg}));
        sum   = 18'(rdata_reg) + 18'(share);
        if (sum > 18'sd32767) sat = 16'sh7fff;
        else if (sum < -18'sd32768) sat = 16'sh8000;
        else sat = sum[ERR_W-1:0];
    end

    // Memory port control
    logic                    ren;
    logic [ADDR_W-1:0]       raddr;
    logic                    wen;
    logic [ADDR_W-1:0]       waddr;
    logic signed [ERR_W-1:0] wdata;
    logic                    out_load;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_load = (state_reg == ST_CALC) && (!out_valid_reg || m_tready);
    assign clearing = state_reg == ST_CLEAR;

    always_comb begin
        ren   = 1'b0;
        raddr = tap_addr;
        wen   = 1'b0;
        waddr = pw_addr_reg;
        wdata = sat;
        case (state_reg)
            ST_CLEAR: begin
                wen   = 1'b1;
                waddr = clr_addr_reg;
                wdata = '0;
            end
            ST_IDLE: begin
                ren   = pop;
                raddr = row_addr(head.slot, head.x);
            end
            ST_CALC: begin
                wen   = out_load;
                waddr = row_addr(cur_reg.slot, cur_reg.x);
                wdata = '0;
            end
            ST_TAP: begin
                ren = tap_ok;
                wen = pw_valid_reg;
            end
            ST_WB: begin
                wen = pw_valid_reg;
            end
            default: ;
        endcase
    end

    // Error memory
    always_ff @(posedge aclk) begin
        if (wen) err_mem[waddr] <= wdata;
        if (ren) rdata_reg <= err_mem[raddr];
    end

    // Sequence one pixel, hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == CLR_LAST) begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        cur_reg   <= head;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (out_load) begin
                        e_reg        <= e_new;
                        out_pix_reg  <= white ? 8'd255 : 8'd0;
                        out_last_reg <= cur_reg.row_end;
                        out_user_reg <= cur_reg.frame_end;
                        k_reg        <= '0;
                        pw_valid_reg <= 1'b0;
                        state_reg    <= ST_TAP;
                    end
                end
                ST_TAP: begin
                    pw_valid_reg <= tap_ok;
                    pw_addr_reg  <= tap_addr;
                    pw_wgt_reg   <= tap.wgt;
                    k_reg        <= k_reg + TAP_W'(1);
                    if (k_reg == last_k) state_reg <= ST_WB;
                end
                ST_WB: begin
                    pw_valid_reg <= 1'b0;
                    state_reg    <= cur_reg.frame_end ? ST_CLEAR : ST_IDLE;
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    `EDD_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_tready, !out_load)
    `EDD_ASSERT_NEXT(a_pop_to_calc, pop, state_reg == ST_CALC)
    `EDD_ASSERT_NEXT(a_frame_clears, state_reg == ST_WB && cur_reg.frame_end, state_reg == ST_CLEAR)

endmodule

FILE: sv/error_diffusion_dither_unit.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_unit
// Error diffusion dither, Floyd-Steinberg or Jarvis-Judice-Ninke kernel.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    s_tdata[7:0] pixel_value
// m_       out  m_tvalid/m_tready    m_tdata[7:0] dithered_pixel, m_tlast row_done,
//                                    m_tuser[0] frame_done
// cfg_     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Each pixel passes through the error memory sequencer as one read of
// the pixel's error, one threshold step, one step per kernel tap with the
// Floyd-Steinberg or Jarvis-Judice-Ninke kernel and a final write back, all
// through the single read and single write port of the memory.
// After reset and after the last pixel of each frame a clearing pass over all
// 3072 words zeroes the error memory; s_tready is low during it.
// A four-entry queue lets the input side run ahead; the result register holds
// a pixel until m_tready, and the sequencer waits only when it is still full.
// ----------------------------------------------------------------------------
module error_diffusion_dither_unit import edd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] dithered_pixel
    output logic                  m_tlast,
    output logic                  m_tuser,   // [0] frame_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    edd_item_t front_item;
    edd_item_t head;
    logic      accept;
    logic      full;
    logic      empty;
    logic      pop;
    logic      clearing;

    // Accept while the queue has room and no clearing pass runs
    assign s_tready  = !full && !clearing;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    edd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (s_tdata),
        .item      (front_item)
    );

    edd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    edd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: verif/edd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion result checker
// Watches the pixel, result and register channels, predicts each dithered
// pixel with its own model of the error rows, and counts mismatches.
// ----------------------------------------------------------------------------
module edd_checker import edd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count,
    output int                    frames_seen
);

    typedef struct packed {
        logic [7:0] level;
        logic       row_done;
        logic       frame_done;
    } dither_out_t;

    dither_out_t      expected_pixels[$];
    logic signed [15:0] err_mem[3][MAX_WIDTH];
    int unsigned      col_pos, row_pos, row_slot;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic             jjn_reg, serp_reg;

    function automatic void clear_frame();
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < MAX_WIDTH; i++) err_mem[s][i] = '0;
        col_pos = 0;
        row_pos = 0;
        row_slot = 0;
    endfunction

    function automatic void spread_error(int slot, int tx, int w, int v);
        int sum;
        if (tx < 0 || tx >= w) return;
        sum = int'(err_mem[slot][tx]) + v;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        err_mem[slot][tx] = sum[15:0];
    endfunction

    // Kernel taps, forward scan: row below, column offset, weight
    function automatic edd_tap_t edd_tap_local(logic jjn, int k);
        edd_tap_t t;
        t = '{row: 2'd0, dx: 3'sd0, wgt: 3'd0};
        if (!jjn) begin
            case (k)
                0: t = '{row: 2'd0, dx:  3'sd1, wgt: 3'd7};
                1: t = '{row: 2'd1, dx: -3'sd1, wgt: 3'd3};
                2: t = '{row: 2'd1, dx:  3'sd0, wgt: 3'd5};
                3: t = '{row: 2'd1, dx:  3'sd1, wgt: 3'd1};
                default: ;
            endcase
        end else begin
            case (k)
                0:  t = '{row: 2'd0, dx:  3'sd1, wgt: 3'd7};
                1:  t = '{row: 2'd0, dx:  3'sd2, wgt: 3'd5};
                2:  t = '{row: 2'd1, dx: -3'sd2, wgt: 3'd3};
                3:  t = '{row: 2'd1, dx: -3'sd1, wgt: 3'd5};
                4:  t = '{row: 2'd1, dx:  3'sd0, wgt: 3'd7};
                5:  t = '{row: 2'd1, dx:  3'sd1, wgt: 3'd5};
                6:  t = '{row: 2'd1, dx:  3'sd2, wgt: 3'd3};
                7:  t = '{row: 2'd2, dx: -3'sd2, wgt: 3'd1};
                8:  t = '{row: 2'd2, dx: -3'sd1, wgt: 3'd3};
                9:  t = '{row: 2'd2, dx:  3'sd0, wgt: 3'd5};
                10: t = '{row: 2'd2, dx:  3'sd1, wgt: 3'd3};
                11: t = '{row: 2'd2, dx:  3'sd2, wgt: 3'd1};
                default: ;
            endcase
        end
        return t;
    endfunction

    // Dither one pixel and advance the scan position
    function automatic dither_out_t dither_pixel(logic [7:0] pix);
        dither_out_t res;
        int w, h, col, x, s0, dv, acc, val, clipped, lvl, e, dx, wgt;
        logic rev;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        col = (col_pos >= w) ? w - 1 : col_pos;
        rev = serp_reg && row_pos[0];
        x = rev ? w - 1 - col : col;
        s0 = row_slot % 3;
        dv = jjn_reg ? 48 : 16;
        acc = err_mem[s0][x];
        err_mem[s0][x] = '0;
        val = int'(pix) + acc / dv;
        clipped = val < 0 ? 0 : (val > 255 ? 255 : val);
        lvl = clipped >= 128 ? 255 : 0;
        e = val - lvl;
        for (int t = 0; t < JJN_TAPS; t++) begin
            edd_tap_t tap;
            tap = edd_tap_local(jjn_reg, t);
            if (tap.wgt == 0) continue;
            dx = rev ? -int'(tap.dx) : int'(tap.dx);
            wgt = tap.wgt;
            spread_error((s0 + tap.row) % 3, x + dx, w, e * wgt);
        end
        res.level = lvl[7:0];
        res.row_done = (col + 1 >= w);
        res.frame_done = res.row_done && (row_pos + 1 >= h);
        if (res.frame_done) clear_frame();
        else if (res.row_done) begin
            col_pos = 0;
            row_pos++;
            row_slot = (s0 + 1) % 3;
        end else col_pos = col + 1;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            width_reg = 11'd1024;
            height_reg = 13'd480;
            jjn_reg = 1'b0;
            serp_reg = 1'b0;
            expected_pixels.delete();
            fail_count <= 0;
            frames_seen <= 0;
        end else begin
            // Predict each accepted pixel
            if (s_tvalid && s_tready)
                expected_pixels.push_back(dither_pixel(s_tdata));
            // Apply register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg = cfg_data[10:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data[12:0];
                    CFG_KERNEL_SEL:   jjn_reg = cfg_data[0];
                    CFG_SERPENTINE:   serp_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                dither_out_t got;
                got = '{level: m_tdata, row_done: m_tlast, frame_done: m_tuser};
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    dither_out_t want;
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                    if (got.frame_done) frames_seen <= frames_seen + 1;
                end
            end
        end
        pending_count <= expected_pixels.size();
    end

endmodule

FILE: verif/tb_error_diffusion_dither_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error diffusion dither testbench
// Drives pixel frames under several image sizes, kernels and scan orders with
// random idling on both sides; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_error_diffusion_dither_unit;
    import edd_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid, s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid, m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast, m_tuser;
    logic                  cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count, pending_count, frames_seen;
    int                    pixels_sent;
    int                    settings_run;
    bit                    calm_mode;
    bit                    sink_stall_ok;

    error_diffusion_dither_unit dut (.*);

    edd_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall bursts, none during the calm tail
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm_mode && sink_stall_ok && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_pixel(logic [7:0] pix);
        if (!calm_mode && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Let every prediction drain, then idle before the next register writes
    task automatic drain_all();
        s_tvalid <= 0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic program_image(int w, int h, bit jjn, bit serp);
        drain_all();
        write_reg(CFG_IMAGE_WIDTH, w[15:0]);
        write_reg(CFG_IMAGE_HEIGHT, h[15:0]);
        write_reg(CFG_KERNEL_SEL, {15'd0, jjn});
        write_reg(CFG_SERPENTINE, {15'd0, serp});
        settings_run++;
    endtask

    // Random frame content: flat areas, ramps, noise and extremes
    task automatic send_frame(int w, int h);
        int style;
        int base;
        style = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                case (style)
                    0: send_pixel(base[7:0]);
                    1: send_pixel(8'((c * 255) / (w > 1 ? w - 1 : 1)));
                    2: send_pixel(8'($urandom));
                    default: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
                endcase
                pixels_sent++;
            end
        end
    endtask

    initial begin
        int w, h;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_valid = 0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = 0;
        calm_mode = 0;
        sink_stall_ok = 1;
        pixels_sent = 0;
        settings_run = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: extremes, both kernels, reversed rows, saturation drive
        program_image(4, 3, 0, 1);
        for (int i = 0; i < 12; i++) send_pixel(i % 3 == 0 ? 8'h00 : (i % 3 == 1 ? 8'hFF : 8'h80));
        program_image(1, 1, 1, 0);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        program_image(3, 2, 1, 1);
        for (int i = 0; i < 6; i++) send_pixel(8'(8'h55 << (i % 2)));
        // Width and height above range act as the maximum; zero acts as one
        program_image(0, 0, 0, 0);
        send_pixel(8'hAA);
        program_image(2047, 1, 1, 1);
        for (int i = 0; i < MAX_WIDTH; i++) send_pixel(i[0] ? 8'hFF : 8'h7F);
        pixels_sent += 1045;

        // Hold the sender until every result has come back
        drain_all();
        sink_stall_ok = 1;

        // Random frames over many settings
        while (pixels_sent < 1750) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            program_image(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (pixels_sent > 1500) calm_mode = 1;
            send_frame(w, h);
        end
        // Frame left open across a register change
        send_pixel(8'h33);
        program_image(MAX_WIDTH, 8191, 1, 0);
        send_frame(3, 1);

        drain_all();
        repeat (3200) @(negedge aclk);
        $display("Covered %0d pixels over %0d register settings, %0d frames completed.",
                 pixels_sent, settings_run, frames_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/edd_pkg.sv
sv/edd_front.sv
sv/edd_queue.sv
sv/edd_back.sv
sv/error_diffusion_dither_unit.sv
verif/edd_checker.sv
verif/tb_error_diffusion_dither_unit.sv
